@@ rtl/ahsct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsct_pkg: shared types, constants and helpers
// Fixed-point constants, handshake structs between the sequencer and its
// arithmetic units, and sign-magnitude helpers for the 64-bit datapath.
// ----------------------------------------------------------------------------
package ahsct_pkg;

  localparam int MAX_HALVINGS_DEF = 32;
  localparam int FRAC_BITS_DEF    = 44;

  localparam int PORT_W    = 32;
  localparam int PORT_FRAC = 28;
  localparam int TOL_W     = 29;
  localparam logic [TOL_W-1:0] TOL_RESET = 29'd268;

  // From this many halvings on the threshold is met, unless the tolerance is zero
  localparam int SHIFT_CAP = 35;

  // Integer bits of a tangent quotient (quotients of 8 or more saturate)
  localparam int QUOT_INT_BITS = 3;

  localparam logic [63:0] PORT_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] WIDE_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

  // Multiplier request and response
  typedef struct packed {
    logic start;
    logic wide;    // clamp to the full 64-bit range instead of the port range
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic        neg;
    logic [63:0] mag;
  } mul_rsp_t;

  // Divider response
  typedef struct packed {
    logic        done;
    logic        flag;
    logic [63:0] value;
  } div_rsp_t;

  // Magnitude of a two's complement value
  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Clamp a magnitude to a limit and apply a sign
  function automatic logic [63:0] sat_mag(input logic neg, input logic [63:0] mag,
                                          input logic [63:0] lim);
    logic [63:0] m;
    m = (mag > lim) ? lim : mag;
    return neg ? (~m + 64'd1) : m;
  endfunction

endpackage

@@ rtl/ahsct_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsct_mul: multi-cycle fixed-point multiplier
// Sign-magnitude 64x64 product built from four 32x32 partial products, then
// rounded half away from zero, scaled down by the fraction bits and clamped.
// ----------------------------------------------------------------------------
module ahsct_mul
  import ahsct_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output mul_rsp_t           rsp
);

  localparam logic [63:0]  LIM = PORT_MAX << (FRAC_BITS - PORT_FRAC);
  localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

  localparam logic [2:0] PP_LAST  = 3'd3;
  localparam logic [2:0] ACC_LAST = 3'd4;
  localparam logic [2:0] FIN      = 3'd5;

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  am;
  logic [63:0]  bm;
  logic         neg;
  logic         wide;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;

  logic [31:0]  ha;
  logic [31:0]  hb;
  logic         over;
  logic [63:0]  r;
  logic [63:0]  lim;
  logic [63:0]  r_sat;

  // Pick operand halves and scale the accumulated product
  always_comb begin
    ha    = cnt[0] ? am[63:32] : am[31:0];
    hb    = cnt[1] ? bm[63:32] : bm[31:0];
    over  = (acc >> (64 + FRAC_BITS)) != '0;
    r     = over ? '1 : acc[FRAC_BITS +: 64];
    lim   = wide ? WIDE_LIM : LIM;
    r_sat = (r > lim) ? lim : r;
  end

  // Step through partial products, accumulate, then finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          am   <= abs64(a);
          bm   <= abs64(b);
          neg  <= a[63] ^ b[63];
          wide <= req.wide;
          acc  <= RND;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else begin
        if (cnt <= PP_LAST) begin
          pp    <= 64'(ha) * 64'(hb);
          pp_sh <= {cnt[0] & cnt[1], cnt[0] ^ cnt[1]};
        end
        if (cnt != '0 && cnt <= ACC_LAST) begin
          acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
        end
        if (cnt == FIN) begin
          rsp.mag  <= r_sat;
          rsp.neg  <= neg;
          rsp.done <= 1'b1;
          busy     <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

@@ rtl/ahsct_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsct_div: bit-serial tangent doubling divider
// Computes 2t/d in fixed point, one quotient bit per cycle by restoring
// division, truncating toward zero and saturating on zero or large quotients.
// ----------------------------------------------------------------------------
module ahsct_div
  import ahsct_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] t,
  input  logic signed [63:0] d,
  output div_rsp_t           rsp
);

  localparam logic [63:0] LIM   = PORT_MAX << (FRAC_BITS - PORT_FRAC);
  localparam int          STEPS = FRAC_BITS + QUOT_INT_BITS;
  localparam int          QW    = STEPS;
  localparam int          CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] INT_END  = CNT_W'(QUOT_INT_BITS);
  localparam logic [CNT_W-1:0] SH_END   = CNT_W'(QUOT_INT_BITS - 1);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} dstate_t;

  dstate_t          state;
  logic [63:0]      rem;
  logic [65:0]      dsh;
  logic [63:0]      dm;
  logic [QW-1:0]    q;
  logic             neg;
  logic             tneg;
  logic [CNT_W-1:0] cnt;

  logic [63:0]      t_mag;
  logic             frac;
  logic [65:0]      trial;
  logic             ge;
  logic [65:0]      diff;
  logic             too_big;
  logic [63:0]      q_full;

  // One restoring step; the divisor shifts down through the integer bits
  always_comb begin
    t_mag   = abs64(t);
    frac    = (cnt >= INT_END);
    trial   = frac ? {1'b0, rem, 1'b0} : {2'b00, rem};
    ge      = (trial >= dsh);
    diff    = trial - dsh;
    too_big = ({3'b000, rem} >= {dm, 3'b000});
    q_full  = 64'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= {t_mag[62:0], 1'b0};
            dm    <= abs64(d);
            neg   <= t[63] ^ d[63];
            tneg  <= t[63];
            state <= D_CHECK;
          end
        end
        // Catch division by zero and quotients of 8 or more
        D_CHECK: begin
          if (dm == '0) begin
            rsp.value <= sat_mag(tneg, LIM, LIM);
            rsp.flag  <= 1'b1;
            rsp.done  <= 1'b1;
            state     <= D_IDLE;
          end else if (too_big) begin
            rsp.value <= sat_mag(neg, LIM, LIM);
            rsp.flag  <= 1'b1;
            rsp.done  <= 1'b1;
            state     <= D_IDLE;
          end else begin
            dsh   <= {dm, 2'b00};
            q     <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[63:0] : trial[63:0];
          q   <= {q[QW-2:0], ge};
          if (cnt < SH_END) begin
            dsh <= dsh >> 1;
          end
          if (cnt == CNT_LAST) begin
            state <= D_FIN;
          end
          cnt <= cnt + 1'b1;
        end
        // Clamp to the port range and apply the sign
        D_FIN: begin
          rsp.value <= sat_mag(neg, q_full, LIM);
          rsp.flag  <= (q_full > LIM);
          rsp.done  <= 1'b1;
          state     <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/angle_halving_sin_cos_tan_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_halving_sin_cos_tan_top: sine, cosine and tangent by angle halving
// Halves the angle until it falls below the tolerance, seeds small-angle
// values and runs the double-angle steps on one shared multiplier and a
// bit-serial divider under a sequencer.
//
//   channel  handshake           payload
//   in       in_valid/in_ready   angle (Q3.28)
//   out      out_valid/out_ready sine, cosine, tangent (Q3.28), tangent_overflow
//   cfg      cfg_we              cfg_wdata (tolerance, unsigned Q1.28)
//
// One item at a time; in_ready is high only while the sequencer is idle.
// The sine and cosine pass doubles ksc times and the tangent pass kt times,
// where ksc and kt are the halving counts. Each product goes through the shared
// multiplier; each tangent step waits on the divider, one quotient bit per
// cycle.
// A result waits in the output register while the next item is taken.
// Reset clears the sequencer, the output valid and the tolerance to 268.
// ----------------------------------------------------------------------------
module angle_halving_sin_cos_tan_top
  import ahsct_pkg::*;
#(
  parameter int MAX_HALVINGS       = MAX_HALVINGS_DEF,
  parameter int INTERNAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PORT_W-1:0] angle,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PORT_W-1:0] sine,
  output logic signed [PORT_W-1:0] cosine,
  output logic signed [PORT_W-1:0] tangent,
  output logic                     tangent_overflow,
  input  logic                     cfg_we,
  input  logic [TOL_W-1:0]         cfg_wdata
);

  localparam int FB_SH = INTERNAL_FRAC_BITS - PORT_FRAC;
  localparam int K_W   = $clog2(MAX_HALVINGS + 1);
  localparam logic [K_W-1:0] K_LAST    = K_W'(MAX_HALVINGS);
  localparam logic [63:0]    LIM       = PORT_MAX << FB_SH;
  localparam logic [63:0]    ONE       = 64'd1 << INTERNAL_FRAC_BITS;
  localparam logic [64:0]    PORT_HALF = (65'd1 << FB_SH) >> 1;

  typedef enum logic [3:0] {
    S_IDLE, S_COUNT, S_RED_SHIFT, S_RED_SAT, S_SQ_WAIT, S_SC_CHK, S_SS_WAIT,
    S_SC_WAIT, S_TAN_CHK, S_TT_WAIT, S_DIV_WAIT, S_OUT
  } state_t;

  state_t             state;
  logic [TOL_W-1:0]   tol;
  logic [PORT_W-1:0]  m;
  logic               neg;
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     ksc;
  logic [K_W-1:0]     kt;
  logic               kt_set;
  logic [63:0]        bnd;
  logic               red_tan;
  logic [63:0]        red_mag;
  logic signed [63:0] s;
  logic signed [63:0] c;
  logic signed [63:0] t;
  logic signed [63:0] d;
  logic [63:0]        s2;
  logic [K_W-1:0]     i;
  logic               tan_flag;
  mul_req_t           mul_req;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  mul_rsp_t           mul_rsp;
  logic               div_start;
  div_rsp_t           div_rsp;

  logic               big;
  logic               tol_zero;
  logic               lt;
  logic               le;
  logic               hit_strict;
  logic               hit_loose;
  logic               at_cap;
  logic [K_W-1:0]     k_sel;
  logic [64:0]        red_sum;
  logic [63:0]        red_next;
  logic [63:0]        red_val;
  logic [63:0]        twice_mag;

  // Round half away from zero into Q3.28 and saturate
  function automatic logic [PORT_W-1:0] to_port(input logic [63:0] v);
    logic [63:0] mg;
    logic [64:0] r;
    mg = abs64(v);
    r  = (65'(mg) + PORT_HALF) >> FB_SH;
    if (r > 65'(PORT_MAX)) r = 65'(PORT_MAX);
    return v[63] ? (~r[PORT_W-1:0] + 32'd1) : r[PORT_W-1:0];
  endfunction

  // Shared arithmetic units
  ahsct_mul #(.FRAC_BITS(INTERNAL_FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .a   (mul_a),
    .b   (mul_b),
    .rsp (mul_rsp)
  );

  ahsct_div #(.FRAC_BITS(INTERNAL_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .t     (t),
    .d     (d),
    .rsp   (div_rsp)
  );

  // Threshold tests, reduced angle and doubled products
  always_comb begin
    big        = (int'(k) >= SHIFT_CAP);
    tol_zero   = (tol == '0);
    lt         = ({32'd0, m} < bnd);
    le         = ({32'd0, m} <= bnd);
    hit_strict = tol_zero ? 1'b0 : (big | lt);
    hit_loose  = tol_zero ? (m == '0) : (big | le);
    at_cap     = (k == K_LAST);
    k_sel      = red_tan ? kt : ksc;
    red_sum    = (65'(m) << FB_SH) + ((65'd1 << k_sel) >> 1);
    red_next   = 64'(red_sum >> k_sel);
    red_val    = sat_mag(neg, red_mag, LIM);
    twice_mag  = {mul_rsp.mag[62:0], 1'b0};
    in_ready   = (state == S_IDLE) && !rst;
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tol           <= TOL_RESET;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
      mul_req.wide  <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_start     <= 1'b0;
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      // Drop the result once transferred
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg      <= angle[PORT_W-1];
            m        <= angle[PORT_W-1] ? (~angle + 32'd1) : angle;
            k        <= '0;
            kt_set   <= 1'b0;
            bnd      <= 64'(tol);
            tan_flag <= 1'b0;
            red_tan  <= 1'b0;
            state    <= S_COUNT;
          end
        end
        // Find both halving counts, one candidate per cycle
        S_COUNT: begin
          if (!kt_set && (hit_loose || at_cap)) begin
            kt     <= k;
            kt_set <= 1'b1;
          end
          if (hit_strict || at_cap) begin
            ksc   <= k;
            state <= S_RED_SHIFT;
          end else begin
            k   <= k + 1'b1;
            bnd <= bnd << 1;
          end
        end
        S_RED_SHIFT: begin
          red_mag <= red_next;
          state   <= S_RED_SAT;
        end
        S_RED_SAT: begin
          if (!red_tan) begin
            s             <= red_val;
            mul_a         <= red_val;
            mul_b         <= red_val;
            mul_req.start <= 1'b1;
            mul_req.wide  <= 1'b0;
            state         <= S_SQ_WAIT;
          end else begin
            t     <= red_val;
            i     <= '0;
            state <= S_TAN_CHK;
          end
        end
        // Seed cosine from the small-angle square
        S_SQ_WAIT: begin
          if (mul_rsp.done) begin
            c     <= ONE - (mul_rsp.mag >> 1);
            i     <= '0;
            state <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (i == ksc) begin
            red_tan <= 1'b1;
            state   <= S_RED_SHIFT;
          end else begin
            mul_a         <= s;
            mul_b         <= s;
            mul_req.start <= 1'b1;
            mul_req.wide  <= 1'b0;
            state         <= S_SS_WAIT;
          end
        end
        S_SS_WAIT: begin
          if (mul_rsp.done) begin
            s2            <= sat_mag(1'b0, twice_mag, LIM);
            mul_a         <= s;
            mul_b         <= c;
            mul_req.start <= 1'b1;
            mul_req.wide  <= 1'b0;
            state         <= S_SC_WAIT;
          end
        end
        S_SC_WAIT: begin
          if (mul_rsp.done) begin
            s     <= sat_mag(mul_rsp.neg, twice_mag, LIM);
            c     <= ONE - s2;
            i     <= i + 1'b1;
            state <= S_SC_CHK;
          end
        end
        S_TAN_CHK: begin
          if (i == kt) begin
            state <= S_OUT;
          end else begin
            mul_a         <= t;
            mul_b         <= t;
            mul_req.start <= 1'b1;
            mul_req.wide  <= 1'b1;
            state         <= S_TT_WAIT;
          end
        end
        S_TT_WAIT: begin
          if (mul_rsp.done) begin
            d         <= ONE - mul_rsp.mag;
            div_start <= 1'b1;
            state     <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            t        <= div_rsp.value;
            tan_flag <= tan_flag | div_rsp.flag;
            i        <= i + 1'b1;
            state    <= S_TAN_CHK;
          end
        end
        // Hold until the output register is free
        S_OUT: begin
          if (!out_valid || out_ready) begin
            sine             <= to_port(s);
            cosine           <= to_port(c);
            tangent          <= to_port(t);
            tangent_overflow <= tan_flag;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ahsct_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsct_checker: port-level checks for the angle halving block
// Watches the handshakes and results over time; bound to the top level.
// ----------------------------------------------------------------------------
module ahsct_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] sine,
  input logic signed [31:0] cosine,
  input logic signed [31:0] tangent,
  input logic               tangent_overflow
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sine) && $stable(cosine)
      && $stable(tangent) && $stable(tangent_overflow))
    else $error("result changed while stalled");

  // One item at a time: a transfer in closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

  // A new result appears only as the sequencer returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while still busy");

  // Cosine never exceeds one
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cosine <= 32'sh1000_0000))
    else $error("cosine above one");

endmodule

bind angle_halving_sin_cos_tan_top ahsct_checker u_ahsct_checker (.*);

@@ dv/angle_halving_sin_cos_tan_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_halving_sin_cos_tan_top_test: self-checking bench for the halving core
// Sends angles through the valid/ready input, predicts sine, cosine, tangent
// and the tangent overflow flag with a bit-exact fixed-point model, and checks
// every output transfer against the oldest prediction. A directed table comes
// first, then random angles under several tolerance settings and idle mixes.
// ----------------------------------------------------------------------------
module angle_halving_sin_cos_tan_top_test;
  import ahsct_pkg::*;

  localparam int FB   = FRAC_BITS_DEF;
  localparam int MAXH = MAX_HALVINGS_DEF;
  localparam int SHIFT_Q = FB - PORT_FRAC;

  localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FB;
  localparam logic signed [63:0] FX_LIM = PORT_MAX << SHIFT_Q;
  localparam logic [TOL_W-1:0] TOL_MAX  = 29'h1000_0000;
  localparam int HALF_PI = 421657428;
  localparam int SEGMENTS = 9;
  localparam int SEG_ITEMS = 50;

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
    logic [31:0] tangent;
    logic        ovf;
  } trig_t;

  typedef struct packed {
    logic [31:0] a;
    logic        fixed;
    trig_t       want;
  } row_t;

  // Directed angles under the reset tolerance; fixed rows carry typed results
  localparam int NROWS = 22;
  localparam row_t DIR_ROWS [NROWS] = '{
    '{32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h1000_0000, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'h1000_0000, 32'hFFFF_FFFF, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h0000_010C, 1'b0, '0},
    '{32'h0000_010B, 1'b0, '0},
    '{32'h0000_010D, 1'b0, '0},
    '{32'hFFFF_FEF4, 1'b0, '0},
    '{32'h0000_0218, 1'b0, '0},
    '{32'h0000_0219, 1'b0, '0},
    '{32'h0C90_FDAA, 1'b0, '0},
    '{32'h1921_FB54, 1'b0, '0},
    '{32'hE6DE_04AC, 1'b0, '0},
    '{32'h3243_F6A9, 1'b0, '0},
    '{32'h4B65_F1FC, 1'b0, '0},
    '{32'h1000_0000, 1'b0, '0},
    '{32'hF000_0000, 1'b0, '0},
    '{32'h4000_0000, 1'b0, '0},
    '{32'h0001_0000, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [PORT_W-1:0] angle     = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PORT_W-1:0] sine;
  logic [PORT_W-1:0] cosine;
  logic [PORT_W-1:0] tangent;
  logic              tangent_overflow;
  logic              cfg_we    = 1'b0;
  logic [TOL_W-1:0]  cfg_wdata = '0;

  logic [TOL_W-1:0] tol_model = TOL_RESET;
  trig_t trig_queue[$];
  int errors = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 77;

  angle_halving_sin_cos_tan_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .angle            (angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sine             (sine),
    .cosine           (cosine),
    .tangent          (tangent),
    .tangent_overflow (tangent_overflow),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : v;
  endfunction

  // Clamp a magnitude to lim and apply the sign
  function automatic logic signed [63:0] clamp_to(input logic neg, input logic [63:0] m,
                                                  input logic [63:0] lim);
    logic [63:0] c;
    c = (m > lim) ? lim : m;
    return neg ? -c : c;
  endfunction

  // Product rounded half away from zero, clamped to lim
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                input logic signed [63:0] y,
                                                input logic [63:0] lim);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, mag_of(x)} * {64'd0, mag_of(y)} + (128'd1 << (FB - 1));
    p = p >> FB;
    r = (p[127:64] != 0) ? '1 : p[63:0];
    return clamp_to(x[63] ^ y[63], r, lim);
  endfunction

  function automatic logic signed [63:0] fx_double(input logic signed [63:0] v);
    return clamp_to(v[63], mag_of(v) << 1, FX_LIM);
  endfunction

  function automatic logic signed [63:0] one_minus(input logic signed [63:0] x);
    logic signed [63:0] d;
    d = FX_ONE - x;
    if (d > FX_LIM) return FX_LIM;
    if (d < -FX_LIM) return -FX_LIM;
    return d;
  endfunction

  // Fewest halvings that bring m under the tolerance, capped at MAXH
  function automatic int halving_count(input logic [63:0] m, input logic [TOL_W-1:0] tol,
                                       input logic strict);
    int k;
    logic [63:0] b;
    logic met;
    for (k = 0; k < MAXH; k++) begin
      if (tol == 0) begin
        met = strict ? 1'b0 : (m == 0);
      end else if (k >= SHIFT_CAP) begin
        met = 1'b1;
      end else begin
        b = {35'd0, tol} << k;
        met = strict ? (m < b) : (m <= b);
      end
      if (met) break;
    end
    return k;
  endfunction

  // Halved angle in the internal format, rounded half away from zero
  function automatic logic signed [63:0] seed_angle(input logic neg, input logic [63:0] m,
                                                    input int k);
    logic [63:0] w;
    w = m << SHIFT_Q;
    if (k > 0) w = (w + (64'd1 << (k - 1))) >> k;
    return clamp_to(neg, w, FX_LIM);
  endfunction

  function automatic logic [31:0] to_q328(input logic signed [63:0] v);
    logic [63:0] m;
    m = mag_of(v);
    m = (m + (64'd1 << (SHIFT_Q - 1))) >> SHIFT_Q;
    if (m > PORT_MAX) m = PORT_MAX;
    return v[63] ? 32'(-m) : m[31:0];
  endfunction

  function automatic trig_t halving_trig(input logic [31:0] a, input logic [TOL_W-1:0] tol);
    logic neg, qneg, flag;
    logic [63:0] m, num, dm, q;
    logic [127:0] wide_q;
    logic signed [63:0] s, c, t, s2, d;
    int ksc, kt, i;
    trig_t r;
    neg = a[31];
    m = neg ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
    ksc = halving_count(m, tol, 1'b1);
    kt = halving_count(m, tol, 1'b0);

    // Sine and cosine: seed, then double ksc times
    s = seed_angle(neg, m, ksc);
    c = one_minus(fx_mul(s, s, FX_LIM) >>> 1);
    for (i = 0; i < ksc; i++) begin
      s2 = fx_double(fx_mul(s, s, FX_LIM));
      s = fx_double(fx_mul(s, c, FX_LIM));
      c = one_minus(s2);
    end

    // Tangent: t' = 2t / (1 - t*t), quotient truncated, saturate and flag
    t = seed_angle(neg, m, kt);
    flag = 1'b0;
    for (i = 0; i < kt; i++) begin
      num = mag_of(t) << 1;
      d = FX_ONE - fx_mul(t, t, WIDE_LIM);
      qneg = t[63] ^ d[63];
      dm = mag_of(d);
      if (dm == 0) begin
        flag = 1'b1;
        t = clamp_to(t[63], FX_LIM, FX_LIM);
      end else if (num / dm >= (64'd1 << QUOT_INT_BITS)) begin
        flag = 1'b1;
        t = clamp_to(qneg, FX_LIM, FX_LIM);
      end else begin
        wide_q = ({64'd0, num} << FB) / {64'd0, dm};
        q = wide_q[63:0];
        if (q > FX_LIM) flag = 1'b1;
        t = clamp_to(qneg, q, FX_LIM);
      end
    end

    r.sine = to_q328(s);
    r.cosine = to_q328(c);
    r.tangent = to_q328(t);
    r.ovf = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    trig_t want;
    if (!rst && out_valid && out_ready) begin
      if (trig_queue.size() == 0) begin
        report_mismatch("result with nothing pending", sine, 32'h0);
      end else begin
        want = trig_queue.pop_front();
        if (sine !== want.sine) report_mismatch("sine", sine, want.sine);
        if (cosine !== want.cosine) report_mismatch("cosine", cosine, want.cosine);
        if (tangent !== want.tangent) report_mismatch("tangent", tangent, want.tangent);
        if (tangent_overflow !== want.ovf)
          report_mismatch("tangent_overflow", {31'd0, tangent_overflow}, {31'd0, want.ovf});
      end
    end
  end

  // Stall the output side at the current rate
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one angle, hold it until the transfer, then queue its prediction
  task automatic send_angle(input logic [31:0] a, input logic fixed, input trig_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    angle <= a;
    do @(posedge clk); while (!in_ready);
    trig_queue.push_back(fixed ? want : halving_trig(a, tol_model));
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trig_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_model = v;
  endtask

  initial begin : stimulus
    int i, seg, n, j, k;
    logic [63:0] b;
    logic [31:0] a;
    logic [TOL_W-1:0] tv;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset tolerance
    for (i = 0; i < NROWS; i++) send_angle(DIR_ROWS[i].a, DIR_ROWS[i].fixed, DIR_ROWS[i].want);

    // Random segments, each with a tolerance setting and one of three idle mixes
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg)
        0, 6:    tv = TOL_MAX;
        2:       tv = 29'd1;
        3, 7:    tv = TOL_W'($urandom_range(1, 4096));
        4:       tv = TOL_RESET;
        default: tv = TOL_W'($urandom_range(1, TOL_MAX));
      endcase
      write_tolerance(tv);
      case (seg / 3)
        0: begin send_idle_pct = 20; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      for (n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        case ($urandom_range(0, 9))
          // small magnitudes
          4: a = $urandom_range(0, 4096);
          // around odd multiples of pi/2, where the tangent blows up
          5: begin
            j = 2 * $urandom_range(0, 2) + 1;
            a = j * HALF_PI + $urandom_range(0, 4000) - 2000;
          end
          // near both ends of the port range
          6: a = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                      : 32'h8000_0000 + $urandom_range(0, 255);
          // on and next to a halving threshold
          7: begin
            k = $urandom_range(0, 31);
            b = {35'd0, tol_model} << k;
            while (b > 64'h7FFF_FFFE && k > 0) begin
              k--;
              b = {35'd0, tol_model} << k;
            end
            a = b[31:0] + $urandom_range(0, 2) - 1;
          end
          // up to one radian, and within plus or minus pi
          8: a = $urandom_range(0, 32'h1000_0000);
          9: a = $urandom_range(0, 32'h3243_F6A9);
          default: a = $urandom;
        endcase
        if (a[31] == 1'b0 && $urandom_range(0, 1) && $urandom_range(0, 9) < 6) a = -a;
        send_angle(a, 1'b0, '0);
      end
    end

    drain_results();
    repeat (2500) @(posedge clk);
    if (errors == 0) begin
      $display("angle_halving_sin_cos_tan_top_test: done, clean");
    end else begin
      $display("angle_halving_sin_cos_tan_top_test: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #100_000_000;
    $display("angle_halving_sin_cos_tan_top_test: done, errors");
    $finish;
  end

endmodule
